// ===== rtl/core/cdsb_pkg.sv =====
// Package with the shared constants, types and state codes of the search-bounds block.
package cdsb_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int WSZ_W      = $clog2(MAX_WIDTH + 1);
	localparam int HSZ_W      = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int LIM_W      = 31;
	localparam int DIV_STEPS  = 41;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SINGLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MULTI  = 2'd3;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SELF,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_CHK,
		ST_DN_CMP,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic        done;
		logic        zero;
		logic [31:0] value;
	} recip_t;

endpackage

// ===== rtl/core/cdsb_if.sv =====
// Channel interfaces for input words, result words and configuration writes.
interface cdsb_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [8:0]  col;
	logic [8:0]  row;
	logic [31:0] road_y;
	logic [31:0] pixel_width;
	logic [15:0] search_up_frac;
	logic [15:0] search_down_frac;
	modport source (output valid, kind, col, row, road_y, pixel_width, search_up_frac,
		search_down_frac, input ready);
	modport sink (input valid, kind, col, row, road_y, pixel_width, search_up_frac,
		search_down_frac, output ready);
endinterface

interface cdsb_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  up_row;
	logic [8:0]  down_row;
	logic [31:0] inv_pixel_width;
	logic        zero_width;
	modport source (output valid, up_row, down_row, inv_pixel_width, zero_width, input ready);
	modport sink (input valid, up_row, down_row, inv_pixel_width, zero_width, output ready);
endinterface

interface cdsb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cdsb_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module cdsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/core/cdsb_recip.sv =====
// Bit-serial restoring divider that forms the saturated reciprocal of the pixel width.
module cdsb_recip (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      divisor,
	output cdsb_pkg::recip_t res
);
	import cdsb_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 sat_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          div_q;
	logic [31:0]          rem_q;
	logic [31:0]          quo_q;
	logic [32:0]          trial;
	logic                 fits;

	assign trial = {rem_q, cnt_q == DIV_CNT_W'(DIV_STEPS - 1)};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			sat_q  <= divisor <= 32'd256;
			zero_q <= divisor == '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign res.done  = done_q;
	assign res.zero  = zero_q;
	assign res.value = sat_q ? 32'hFFFF_FFFF : quo_q;

`ifndef SYNTH
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("divider busy and done together");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q) else $error("divider did not start");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 && !start |=> done_q) else $error("divider did not finish");
`endif
endmodule

// ===== rtl/core/column_displacement_search_bounds.sv =====
// Top level: per-pixel store and column walk that find displacement search bounds.
// A load word is written straight into the store in the same cycle that it is taken.
// A compute word inside the frame reads its own entry, then walks up and then down its column,
// while the 41-step serial divider runs alongside the walks; one outside the frame is dropped.
// The result word is registered once both finish and the output register is free,
// and no input word is taken until it has been posted.
// Reset clears control and restores configuration defaults; the store is undefined until written.
module column_displacement_search_bounds (
	input  logic clk,
	input  logic arst_n,
	cdsb_in_if.sink    in_ch,
	cdsb_out_if.source out_ch,
	cdsb_cfg_if.sink   cfg
);
	import cdsb_pkg::*;

	state_t            state_q, state_d;
	logic [9:0]        fw_q, fh_q;
	logic [LIM_W-1:0]  lim_s_q, lim_m_q;
	logic [WSZ_W-1:0]  w_eff;
	logic [HSZ_W-1:0]  h_eff;
	logic [POS_W-1:0]  col_q, row_q, u_q, d_q;
	logic [31:0]       self_q;
	logic [LIM_W-1:0]  lim_q;
	logic [15:0]       fu_q, fd_q;
	logic [ADDR_W-1:0] addr;
	logic              we;
	logic [31:0]       ry_rdata;
	logic [63:0]       px_rdata;
	logic              acc, in_frame, load_ok;
	logic              up_stop, dn_stop, up_brk, dn_brk;
	logic [32:0]       up_diff, dn_diff;
	logic              div_start;
	recip_t            rcp;
	logic              out_valid_q;
	logic              post;

	function automatic logic [ADDR_W-1:0] pix_addr(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c));
	endfunction

	assign w_eff = (fw_q == '0) ? WSZ_W'(1) :
		(WSZ_W'(fw_q) > WSZ_W'(MAX_WIDTH)) ? WSZ_W'(MAX_WIDTH) : WSZ_W'(fw_q);
	assign h_eff = (fh_q == '0) ? HSZ_W'(1) :
		(HSZ_W'(fh_q) > HSZ_W'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) : HSZ_W'(fh_q);

	assign acc      = in_ch.valid && in_ch.ready;
	assign in_frame = (WSZ_W'(in_ch.col) < w_eff) && (HSZ_W'(in_ch.row) < h_eff);
	assign load_ok  = (32'(in_ch.col) < 32'(MAX_WIDTH)) && (32'(in_ch.row) < 32'(MAX_HEIGHT));

	assign up_stop = (u_q == '0) || ({11'b0, u_q, 16'b0} <= 36'(fu_q) * 36'(h_eff));
	assign dn_stop = (32'(d_q) >= 32'(h_eff) - 32'd1) ||
		({11'b0, d_q, 16'b0} >= 36'(fd_q) * 36'(h_eff));
	assign up_diff = {ry_rdata[31], ry_rdata} - {self_q[31], self_q};
	assign dn_diff = {self_q[31], self_q} - {ry_rdata[31], ry_rdata};
	assign up_brk  = $signed(up_diff) > $signed({2'b00, lim_q});
	assign dn_brk  = $signed(dn_diff) > $signed({2'b00, lim_q});
	assign post    = state_q == ST_WAIT && rcp.done && (!out_valid_q || out_ch.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && in_ch.kind == KIND_COMPUTE && in_frame) state_d = ST_SELF;
			end
			ST_SELF:   state_d = ST_UP_CHK;
			ST_UP_CHK: state_d = up_stop ? ST_DN_CHK : ST_UP_CMP;
			ST_UP_CMP: state_d = up_brk ? ST_DN_CHK : ST_UP_CHK;
			ST_DN_CHK: state_d = dn_stop ? ST_WAIT : ST_DN_CMP;
			ST_DN_CMP: state_d = dn_brk ? ST_WAIT : ST_DN_CHK;
			ST_WAIT: begin
				if (post) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = state_q == ST_IDLE;
		we          = 1'b0;
		div_start   = 1'b0;
		addr        = pix_addr(in_ch.row, in_ch.col);
		unique case (state_q)
			ST_IDLE:   we = acc && in_ch.kind == KIND_LOAD && load_ok;
			ST_SELF:   div_start = 1'b1;
			ST_UP_CHK: addr = pix_addr(u_q, col_q);
			ST_DN_CHK: addr = pix_addr(d_q, col_q);
			default:   addr = pix_addr(in_ch.row, in_ch.col);
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fw_q        <= 10'd512;
			fh_q        <= 10'd512;
			lim_s_q     <= '0;
			lim_m_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_FRAME_WIDTH:  fw_q    <= cfg.data[9:0];
					REG_FRAME_HEIGHT: fh_q    <= cfg.data[9:0];
					REG_LIMIT_SINGLE: lim_s_q <= cfg.data[LIM_W-1:0];
					REG_LIMIT_MULTI:  lim_m_q <= cfg.data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			col_q <= in_ch.col;
			row_q <= in_ch.row;
			lim_q <= in_ch.col[0] ? lim_m_q : lim_s_q;
		end
		if (state_q == ST_SELF) begin
			self_q <= ry_rdata;
			fu_q   <= px_rdata[47:32];
			fd_q   <= px_rdata[63:48];
			u_q    <= row_q;
			d_q    <= row_q;
		end
		if (state_q == ST_UP_CMP && !up_brk) u_q <= u_q - 1'b1;
		if (state_q == ST_DN_CMP && !dn_brk) d_q <= d_q + 1'b1;
		if (post) begin
			out_ch.up_row          <= u_q;
			out_ch.down_row        <= d_q;
			out_ch.inv_pixel_width <= rcp.value;
			out_ch.zero_width      <= rcp.zero;
		end
	end

	assign out_ch.valid = out_valid_q;

	cdsb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_road_y_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (in_ch.road_y),
		.rdata (ry_rdata)
	);

	cdsb_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_pixel_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata ({in_ch.search_down_frac, in_ch.search_up_frac, in_ch.pixel_width}),
		.rdata (px_rdata)
	);

	cdsb_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (px_rdata[31:0]),
		.res     (rcp)
	);

`ifndef SYNTH
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_IDLE) else $error("store written outside idle");
	a_up_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP_CHK || state_q == ST_UP_CMP) |-> u_q <= row_q)
		else $error("upward walk passed its start row");
	a_dn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DN_CHK || state_q == ST_DN_CMP) |-> d_q >= row_q)
		else $error("downward walk passed its start row");
	a_post_done: assert property (@(posedge clk) disable iff (!arst_n)
		post |=> out_valid_q && state_q == ST_IDLE) else $error("result not posted");
`endif
endmodule

// ===== verif/tb_column_displacement_search_bounds.sv =====
// Self-checking testbench for column_displacement_search_bounds: directed and random pixel loads and bound computes.
module tb_column_displacement_search_bounds;
	import cdsb_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int DRAIN_WAIT = 2300;
	localparam int HOLD_LEN   = 3000;
	localparam int CYCLE_CAP  = 4000000;

	typedef struct {
		logic        kind;
		logic [8:0]  col;
		logic [8:0]  row;
		logic [31:0] road_y;
		logic [31:0] pixel_width;
		logic [15:0] up_frac;
		logic [15:0] down_frac;
	} word_t;

	typedef struct {
		logic [8:0]  up_row;
		logic [8:0]  down_row;
		logic [31:0] inv_width;
		logic        zero_width;
	} bounds_t;

	logic clk;
	logic arst_n;

	cdsb_in_if  in_ch();
	cdsb_out_if out_ch();
	cdsb_cfg_if cfg();

	column_displacement_search_bounds u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg   (cfg)
	);

	word_t   pending_words[$];
	bounds_t bounds_expected[$];
	logic [31:0] road_y_mem[int];
	logic [31:0] width_mem[int];
	logic [31:0] frac_mem[int];
	logic [9:0]  cfg_fw;
	logic [9:0]  cfg_fh;
	logic [30:0] cfg_ls;
	logic [30:0] cfg_lm;
	word_t   drive_word;
	int      idle_pct;
	int      mismatches;
	int      cycles = 0;
	logic    hold_req;
	int      hold_cnt = 0;
	logic    holding;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic int clamp_sz(logic [9:0] v);
		if (v == 0) return 1;
		if (v > 512) return 512;
		return int'(v);
	endfunction

	function automatic void predict_bounds(word_t w);
		int a, h, fwe, u, d;
		longint self, lim, fu, fd;
		logic [63:0] inv;
		bounds_t b;
		a = int'(w.row) * MAX_WIDTH + int'(w.col);
		if (w.kind == KIND_LOAD) begin
			road_y_mem[a] = w.road_y;
			width_mem[a] = w.pixel_width;
			frac_mem[a] = {w.down_frac, w.up_frac};
			return;
		end
		fwe = clamp_sz(cfg_fw);
		h = clamp_sz(cfg_fh);
		if (int'(w.col) >= fwe || int'(w.row) >= h) return;
		self = sx(road_y_mem[a]);
		lim = w.col[0] ? longint'(cfg_lm) : longint'(cfg_ls);
		fu = longint'(frac_mem[a][15:0]);
		fd = longint'(frac_mem[a][31:16]);
		u = int'(w.row);
		forever begin
			if (u == 0) break;
			if (longint'(u) * 65536 <= fu * h) break;
			if (sx(road_y_mem[u * MAX_WIDTH + int'(w.col)]) - self > lim) break;
			u--;
		end
		d = int'(w.row);
		forever begin
			if (d >= h - 1) break;
			if (longint'(d) * 65536 >= fd * h) break;
			if (self - sx(road_y_mem[d * MAX_WIDTH + int'(w.col)]) > lim) break;
			d++;
		end
		if (width_mem[a] == 0) begin
			inv = 64'hFFFF_FFFF;
		end else begin
			inv = (64'd1 << 40) / {32'd0, width_mem[a]};
			if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
		end
		b.up_row = u[8:0];
		b.down_row = d[8:0];
		b.inv_width = inv[31:0];
		b.zero_width = (width_mem[a] == 0);
		bounds_expected.push_back(b);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid) predict_bounds(drive_word);
				if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
					drive_word = pending_words.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.kind <= drive_word.kind;
					in_ch.col <= drive_word.col;
					in_ch.row <= drive_word.row;
					in_ch.road_y <= drive_word.road_y;
					in_ch.pixel_width <= drive_word.pixel_width;
					in_ch.search_up_frac <= drive_word.up_frac;
					in_ch.search_down_frac <= drive_word.down_frac;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
	end
	assign holding = hold_req && hold_cnt < HOLD_LEN;

	always @(posedge clk or negedge arst_n) begin
		bounds_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (bounds_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result word: up %0d down %0d",
						out_ch.up_row, out_ch.down_row);
				end else begin
					e = bounds_expected.pop_front();
					if (out_ch.up_row !== e.up_row || out_ch.down_row !== e.down_row ||
						out_ch.inv_pixel_width !== e.inv_width ||
						out_ch.zero_width !== e.zero_width) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp up %0d down %0d inv %h z %b, got up %0d down %0d inv %h z %b",
								e.up_row, e.down_row, e.inv_width, e.zero_width,
								out_ch.up_row, out_ch.down_row, out_ch.inv_pixel_width,
								out_ch.zero_width);
					end
				end
			end
			out_ch.ready <= !holding && ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("tb_column_displacement_search_bounds: FAIL");
			$finish;
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  cfg_fw = val[9:0];
			REG_FRAME_HEIGHT: cfg_fh = val[9:0];
			REG_LIMIT_SINGLE: cfg_ls = val[30:0];
			default:          cfg_lm = val[30:0];
		endcase
	endtask

	task automatic wait_quiet();
		while (pending_words.size() > 0 || in_ch.valid || bounds_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic push_word(logic kind, int col, int row, logic [31:0] ry, logic [31:0] pw,
		logic [15:0] uf, logic [15:0] df);
		word_t w;
		w.kind = kind;
		w.col = col[8:0];
		w.row = row[8:0];
		w.road_y = ry;
		w.pixel_width = pw;
		w.up_frac = uf;
		w.down_frac = df;
		pending_words.push_back(w);
	endtask

	function automatic logic [31:0] rand_width();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return $urandom_range(255);
			2: return 32'hFFFF_FFFF;
			3: return 32'd256;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_frac();
		if ($urandom_range(1)) return $urandom_range(4095);
		return $urandom;
	endfunction

	task automatic fill_column(int col, int first, int last, int scale);
		int base;
		base = $signed($urandom) >>> 4;
		for (int r = first; r <= last; r++)
			push_word(KIND_LOAD, col, r, base + ($signed($urandom) >>> (31 - scale)),
				rand_width(), rand_frac(), rand_frac());
	endtask

	initial begin
		int cols[$];
		int h, fwe, scale, n, c, r;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		hold_req = 1'b0;
		mismatches = 0;
		idle_pct = 31;
		cfg_fw = 10'd512;
		cfg_fh = 10'd512;
		cfg_ls = '0;
		cfg_lm = '0;
		repeat (2) @(posedge clk);
		arst_n = 1'b1;

		fill_column(0, 0, 0, 18);
		fill_column(0, 96, 100, 18);
		fill_column(0, 504, 511, 18);
		fill_column(511, 0, 0, 18);
		fill_column(511, 250, 262, 18);
		fill_column(511, 296, 304, 18);
		push_word(KIND_LOAD, 0, 511, 32'h7FFF_FFFF, 32'd0, 16'd64512, 16'hFFFF);
		push_word(KIND_LOAD, 1, 0, 32'h8000_0000, 32'd1, 16'hFFFF, 16'd0);
		push_word(KIND_LOAD, 511, 256, 32'd0, 32'd255, 16'd32000, 16'd33536);
		push_word(KIND_LOAD, 511, 300, 32'd5, 32'hFFFF_FFFF, 16'd37888, 16'd38912);
		push_word(KIND_LOAD, 0, 100, 32'd7, 32'd256, 16'd12288, 16'd0);
		push_word(KIND_COMPUTE, 0, 511, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 1, 0, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 511, 256, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 511, 300, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 0, 100, 0, 0, 0, 0);
		wait_quiet();
		cfg_write(REG_LIMIT_SINGLE, 32'hFFFF_FFFF);
		cfg_write(REG_LIMIT_MULTI, 32'h7FFF_FFFF);
		push_word(KIND_COMPUTE, 0, 511, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 1, 0, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 511, 300, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 0, 100, 0, 0, 0, 0);
		wait_quiet();
		cfg_write(REG_FRAME_WIDTH, 32'd1023);
		cfg_write(REG_FRAME_HEIGHT, 32'd0);
		push_word(KIND_COMPUTE, 0, 0, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 511, 0, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 1, 1, 0, 0, 0, 0);
		wait_quiet();
		cfg_write(REG_FRAME_WIDTH, 32'd0);
		cfg_write(REG_FRAME_HEIGHT, 32'd1023);
		push_word(KIND_COMPUTE, 0, 100, 0, 0, 0, 0);
		push_word(KIND_COMPUTE, 1, 10, 0, 0, 0, 0);
		wait_quiet();

		for (int ph = 0; ph < 6; ph++) begin
			h = $urandom_range(2, 12);
			scale = $urandom_range(12, 22);
			cfg_write(REG_FRAME_HEIGHT, h);
			cfg_write(REG_FRAME_WIDTH, (ph % 2) ? $urandom_range(1, 511) : 512);
			cfg_write(REG_LIMIT_SINGLE, $urandom_range(0, 1 << scale));
			cfg_write(REG_LIMIT_MULTI, $urandom_range(0, 1 << scale));
			fwe = clamp_sz(cfg_fw);
			cols = '{0, fwe - 1, $urandom_range(0, fwe - 1), 511};
			if (fwe > 1) cols.push_back(fwe - 2);
			foreach (cols[i]) fill_column(cols[i], 0, h - 1, scale);
			idle_pct = (ph == 2) ? 0 : 31;
			n = 45;
			for (int k = 0; k < n; k++) begin
				c = cols[$urandom_range(0, cols.size() - 1)];
				r = $urandom_range(0, h - 1);
				case ($urandom_range(9))
					0: push_word(KIND_LOAD, c, r, $urandom, rand_width(), $urandom, $urandom);
					1: push_word(KIND_COMPUTE, c, $urandom_range(h, 511), $urandom, $urandom,
						$urandom, $urandom);
					default: push_word(KIND_COMPUTE, c, r, $urandom, $urandom, $urandom, $urandom);
				endcase
			end
			if (ph == 4) hold_req = 1'b1;
			wait_quiet();
		end
		idle_pct = 31;

		while (bounds_expected.size() > 0 || pending_words.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && bounds_expected.size() == 0) begin
			$display("tb_column_displacement_search_bounds: PASS");
		end else begin
			$display("tb_column_displacement_search_bounds: FAIL");
		end
		$finish;
	end

endmodule
